/* rtl/mat3_inverse_with_fallback_assert.svh */
// ------------------------------------------------------------------------
// mat3 inverse assertion macros
// shared concurrent assertion forms, clocked on clk, off during reset
// ------------------------------------------------------------------------
`ifndef MAT3_INVERSE_WITH_FALLBACK_ASSERT_SVH
`define MAT3_INVERSE_WITH_FALLBACK_ASSERT_SVH

// same-cycle implication
`define MI3_ASSERT_IMPLIES(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("mat3 inverse assertion failed");

// next-cycle implication
`define MI3_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("mat3 inverse assertion failed");

`endif

/* rtl/mi3_pkg.sv */
// ------------------------------------------------------------------------
// mi3_pkg
// types and constants shared by the 3x3 inverse pipeline
// ------------------------------------------------------------------------
package mi3_pkg;

    localparam int ELEM_IN_W  = 16;
    localparam int ELEM_OUT_W = 32;
    localparam int N_ELEM     = 9;
    localparam int COF_W      = 33;
    localparam int CMAG_W     = 32;
    localparam int DET_W      = 49;
    localparam int DN_W       = 48;
    localparam int BLEN_W     = 6;
    localparam int QUO_W      = 33;
    localparam int REM_W      = DN_W + 1;
    localparam int DIV_STAGES = QUO_W;
    localparam int THR_W      = 20;
    localparam int FB_W       = 31;

    localparam logic [THR_W-1:0] THR_RESET = THR_W'(7);
    localparam logic [FB_W-1:0]  FB_RESET  = FB_W'(65543);

    // result status codes
    typedef enum logic [1:0] {
        ST_INVERTED = 2'd0,
        ST_SINGULAR = 2'd1,
        ST_OVERFLOW = 2'd2
    } status_t;

    // configuration register indexes
    typedef enum logic [0:0] {
        CFG_THRESHOLD = 1'b0,
        CFG_FALLBACK  = 1'b1
    } cfg_index_t;

    // item data that rides alongside the reciprocal divider
    typedef struct packed {
        logic [N_ELEM-1:0][CMAG_W-1:0] cmag;
        logic [N_ELEM-1:0]             cneg;
        logic                          dneg;
        logic [BLEN_W-1:0]             blen;
        logic                          singular;
        logic                          zero;
    } mi3_side_t;

endpackage

/* rtl/mat3_inverse_with_fallback.sv */
// pipeline: 7 front stages, 33 divider stages and 4 back stages between input
//   transaction and output valid
// throughput: one matrix per cycle; the whole pipeline advances whenever the
//   output register is empty or being taken
// reset: asynchronous active-low, clears all valid bits and sets the
//   threshold to 7 and the fallback diagonal to 65543
// ------------------------------------------------------------------------
// mat3_inverse_with_fallback
// 3x3 Q4.12 matrix inverse by adjugate and one shared reciprocal, Q16.16
// result with singular and overflow fallback to a diagonal matrix
// ------------------------------------------------------------------------
module mat3_inverse_with_fallback (
    input  logic          clk,
    input  logic          rst_n,
    // fields low to high: in_r0c0 .. in_r2c2, 16 bits each
    input  logic [143:0]  s_tdata,
    input  logic          s_tvalid,
    output logic          s_tready,
    // fields low to high: out_r0c0 .. out_r2c2, 32 bits each
    output logic [287:0]  m_tdata,
    // fields low to high: status
    output logic [1:0]    m_tuser,
    output logic          m_tvalid,
    input  logic          m_tready,
    input  logic          cfg_we,
    input  logic [0:0]    cfg_addr,
    input  logic [30:0]   cfg_wdata
);
    import mi3_pkg::*;

    logic adv;

    // configuration registers
    logic [THR_W-1:0] thr_reg;
    logic [FB_W-1:0]  fb_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg <= THR_RESET;
            fb_reg  <= FB_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index_t'(cfg_addr))
                CFG_THRESHOLD: thr_reg <= cfg_wdata[THR_W-1:0];
                CFG_FALLBACK:  fb_reg  <= cfg_wdata[FB_W-1:0];
                default:       thr_reg <= thr_reg;
            endcase
        end
    end

    // pipeline moves when the output register can take a new item
    logic out_valid_reg;
    assign adv      = !out_valid_reg || m_tready;
    assign s_tready = adv;

    // front valid chain
    logic v_reg [1:7];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 1; i <= 7; i++)
            begin
                v_reg[i] <= 1'b0;
            end
        end
        else if (adv)
        begin
            v_reg[1] <= s_tvalid;
            for (int i = 2; i <= 7; i++)
            begin
                v_reg[i] <= v_reg[i-1];
            end
        end
    end

    // stage 1: the eighteen element products
    logic signed [ELEM_IN_W-1:0] a [N_ELEM];
    logic signed [31:0] pp_next [N_ELEM];
    logic signed [31:0] pn_next [N_ELEM];
    logic signed [31:0] pp_reg  [N_ELEM];
    logic signed [31:0] pn_reg  [N_ELEM];
    logic signed [ELEM_IN_W-1:0] r0_s1_reg [3];

    always_comb
    begin
        for (int k = 0; k < N_ELEM; k++)
        begin
            a[k] = s_tdata[k*ELEM_IN_W +: ELEM_IN_W];
        end
        pp_next[0] = a[4] * a[8];  pn_next[0] = a[5] * a[7];
        pp_next[1] = a[2] * a[7];  pn_next[1] = a[1] * a[8];
        pp_next[2] = a[1] * a[5];  pn_next[2] = a[2] * a[4];
        pp_next[3] = a[5] * a[6];  pn_next[3] = a[3] * a[8];
        pp_next[4] = a[0] * a[8];  pn_next[4] = a[2] * a[6];
        pp_next[5] = a[2] * a[3];  pn_next[5] = a[0] * a[5];
        pp_next[6] = a[3] * a[7];  pn_next[6] = a[4] * a[6];
        pp_next[7] = a[1] * a[6];  pn_next[7] = a[0] * a[7];
        pp_next[8] = a[0] * a[4];  pn_next[8] = a[1] * a[3];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            pp_reg <= pp_next;
            pn_reg <= pn_next;
            for (int j = 0; j < 3; j++)
            begin
                r0_s1_reg[j] <= a[j];
            end
        end
    end

    // stage 2: cofactors
    logic signed [COF_W-1:0]     cof_reg [N_ELEM];
    logic signed [ELEM_IN_W-1:0] r0_s2_reg [3];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int k = 0; k < N_ELEM; k++)
            begin
                cof_reg[k] <= $signed({pp_reg[k][31], pp_reg[k]})
                            - $signed({pn_reg[k][31], pn_reg[k]});
            end
            r0_s2_reg <= r0_s1_reg;
        end
    end

    // stage 3: expansion terms along row 0, cofactor magnitudes
    logic signed [DET_W-1:0] dt_next [3];
    logic signed [DET_W-1:0] dt_reg  [3];
    logic [COF_W-1:0]        cneg_full [N_ELEM];
    logic [N_ELEM-1:0][CMAG_W-1:0] cmag_s3_reg, cmag_s4_reg, cmag_s5_reg, cmag_s6_reg;
    logic [N_ELEM-1:0]             cneg_s3_reg, cneg_s4_reg, cneg_s5_reg, cneg_s6_reg;

    always_comb
    begin
        dt_next[0] = r0_s2_reg[0] * cof_reg[0];
        dt_next[1] = r0_s2_reg[1] * cof_reg[3];
        dt_next[2] = r0_s2_reg[2] * cof_reg[6];
        for (int k = 0; k < N_ELEM; k++)
        begin
            cneg_full[k] = COF_W'(-cof_reg[k]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            dt_reg <= dt_next;
            for (int k = 0; k < N_ELEM; k++)
            begin
                cneg_s3_reg[k] <= cof_reg[k][COF_W-1];
                cmag_s3_reg[k] <= cof_reg[k][COF_W-1] ? cneg_full[k][CMAG_W-1:0]
                                                      : cof_reg[k][CMAG_W-1:0];
            end
        end
    end

    // stage 4: determinant
    logic signed [DET_W-1:0] det_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            det_reg     <= dt_reg[0] + dt_reg[1] + dt_reg[2];
            cmag_s4_reg <= cmag_s3_reg;
            cneg_s4_reg <= cneg_s3_reg;
        end
    end

    // stage 5: magnitude, sign and singular test
    logic [DET_W-1:0] det_neg;
    logic [DN_W-1:0]  dmag_next;
    logic [DN_W-1:0]  dmag_s5_reg, dmag_s6_reg;
    logic             dneg_s5_reg, dneg_s6_reg, dneg_s7_reg;
    logic             sing_s5_reg, sing_s6_reg, sing_s7_reg;
    logic             zero_s5_reg, zero_s6_reg, zero_s7_reg;

    assign det_neg   = DET_W'(-det_reg);
    assign dmag_next = det_reg[DET_W-1] ? det_neg[DN_W-1:0] : det_reg[DN_W-1:0];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            dmag_s5_reg <= dmag_next;
            dneg_s5_reg <= det_reg[DET_W-1];
            sing_s5_reg <= dmag_next < {{(DN_W-THR_W){1'b0}}, thr_reg};
            zero_s5_reg <= dmag_next == '0;
            cmag_s5_reg <= cmag_s4_reg;
            cneg_s5_reg <= cneg_s4_reg;
        end
    end

    // stage 6: bit length of the magnitude
    logic [BLEN_W-1:0] blen_next;
    logic [BLEN_W-1:0] blen_s6_reg;

    always_comb
    begin
        blen_next = '0;
        for (int i = 0; i < DN_W; i++)
        begin
            if (dmag_s5_reg[i])
            begin
                blen_next = BLEN_W'(i + 1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            blen_s6_reg <= blen_next;
            dmag_s6_reg <= dmag_s5_reg;
            dneg_s6_reg <= dneg_s5_reg;
            sing_s6_reg <= sing_s5_reg;
            zero_s6_reg <= zero_s5_reg;
            cmag_s6_reg <= cmag_s5_reg;
            cneg_s6_reg <= cneg_s5_reg;
        end
    end

    // stage 7: normalize the divisor to a set top bit
    logic [DN_W-1:0]   dn_reg;
    logic [BLEN_W-1:0] lshift;
    mi3_side_t         side_s7;
    logic [BLEN_W-1:0] blen_s7_reg;
    logic [N_ELEM-1:0][CMAG_W-1:0] cmag_s7_reg;
    logic [N_ELEM-1:0]             cneg_s7_reg;

    assign lshift = BLEN_W'(DN_W) - blen_s6_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            dn_reg      <= dmag_s6_reg << lshift;
            blen_s7_reg <= blen_s6_reg;
            dneg_s7_reg <= dneg_s6_reg;
            sing_s7_reg <= sing_s6_reg;
            zero_s7_reg <= zero_s6_reg;
            cmag_s7_reg <= cmag_s6_reg;
            cneg_s7_reg <= cneg_s6_reg;
        end
    end

    always_comb
    begin
        side_s7.cmag     = cmag_s7_reg;
        side_s7.cneg     = cneg_s7_reg;
        side_s7.dneg     = dneg_s7_reg;
        side_s7.blen     = blen_s7_reg;
        side_s7.singular = sing_s7_reg;
        side_s7.zero     = zero_s7_reg;
    end

    // shared reciprocal
    logic             div_valid;
    logic [QUO_W-1:0] div_quo;
    mi3_side_t        div_side;

    mi3_recip u_recip (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (v_reg[7]),
        .dn        (dn_reg),
        .in_side   (side_s7),
        .out_valid (div_valid),
        .quo       (div_quo),
        .out_side  (div_side)
    );

    // back valid chain
    logic vb_reg [1:3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vb_reg[1]     <= 1'b0;
            vb_reg[2]     <= 1'b0;
            vb_reg[3]     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            vb_reg[1]     <= div_valid;
            vb_reg[2]     <= vb_reg[1];
            vb_reg[3]     <= vb_reg[2];
            out_valid_reg <= vb_reg[3];
        end
    end

    // back stage 1: low 32 bits of the reciprocal times each cofactor
    logic [63:0] plo_next [N_ELEM];
    logic [63:0] plo_reg  [N_ELEM];
    logic        q32_reg;
    mi3_side_t   side_b1_reg, side_b2_reg, side_b3_reg;

    always_comb
    begin
        for (int k = 0; k < N_ELEM; k++)
        begin
            plo_next[k] = div_side.cmag[k] * div_quo[31:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            plo_reg     <= plo_next;
            q32_reg     <= div_quo[QUO_W-1];
            side_b1_reg <= div_side;
        end
    end

    // back stage 2: add the reciprocal's top bit
    logic [64:0] prod_reg [N_ELEM];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int k = 0; k < N_ELEM; k++)
            begin
                prod_reg[k] <= {1'b0, plo_reg[k]}
                             + (q32_reg ? {1'b0, side_b1_reg.cmag[k], 32'b0} : 65'd0);
            end
            side_b2_reg <= side_b1_reg;
        end
    end

    // back stage 3: scale back and round half away from zero
    logic [6:0]  rshift;
    logic [64:0] sh [N_ELEM];
    logic [64:0] rnd [N_ELEM];
    logic [62:0] mag_reg [N_ELEM];

    assign rshift = 7'(side_b2_reg.blen) + 7'd2;

    always_comb
    begin
        for (int k = 0; k < N_ELEM; k++)
        begin
            sh[k]  = prod_reg[k] >> rshift;
            rnd[k] = (sh[k] + 65'd1) >> 1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int k = 0; k < N_ELEM; k++)
            begin
                mag_reg[k] <= rnd[k][62:0];
            end
            side_b3_reg <= side_b2_reg;
        end
    end

    // back stage 4: sign, range check, fallback select
    logic [N_ELEM-1:0]                 neg_k;
    logic [N_ELEM-1:0]                 ovf_k;
    logic [N_ELEM-1:0][ELEM_OUT_W-1:0] elem;
    logic [N_ELEM-1:0][ELEM_OUT_W-1:0] data_next;
    status_t                           status_next;
    logic [N_ELEM-1:0][ELEM_OUT_W-1:0] data_reg;
    logic [1:0]                        user_reg;

    always_comb
    begin
        for (int k = 0; k < N_ELEM; k++)
        begin
            neg_k[k] = (mag_reg[k] != '0) && (side_b3_reg.cneg[k] ^ side_b3_reg.dneg);
            ovf_k[k] = neg_k[k] ? (mag_reg[k] > 63'h8000_0000)
                                : (mag_reg[k] > 63'h7FFF_FFFF);
            elem[k]  = neg_k[k] ? ELEM_OUT_W'(~mag_reg[k][31:0] + 32'd1)
                                : mag_reg[k][31:0];
        end
        if (side_b3_reg.singular)
        begin
            status_next = ST_SINGULAR;
        end
        else if (side_b3_reg.zero || (ovf_k != '0))
        begin
            status_next = ST_OVERFLOW;
        end
        else
        begin
            status_next = ST_INVERTED;
        end
        for (int k = 0; k < N_ELEM; k++)
        begin
            if (status_next == ST_INVERTED)
            begin
                data_next[k] = elem[k];
            end
            else if (k == 0 || k == 4 || k == 8)
            begin
                data_next[k] = {1'b0, fb_reg};
            end
            else
            begin
                data_next[k] = '0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            data_reg <= data_next;
            user_reg <= status_next;
        end
    end

    assign m_tdata  = data_reg;
    assign m_tuser  = user_reg;
    assign m_tvalid = out_valid_reg;

    // checks
`include "mat3_inverse_with_fallback_assert.svh"

    `MI3_ASSERT_IMPLIES(a_fallback_offdiag, m_tvalid && (m_tuser != ST_INVERTED), (m_tdata[63:32] == 32'd0) && (m_tdata[127:96] == 32'd0) && (m_tdata[255:224] == 32'd0))
    `MI3_ASSERT_IMPLIES(a_fallback_diag, m_tvalid && (m_tuser != ST_INVERTED), (m_tdata[31:0] == {1'b0, fb_reg}) && (m_tdata[287:256] == {1'b0, fb_reg}))
    `MI3_ASSERT_NEXT(a_accept_enters, s_tvalid && s_tready, v_reg[1])

endmodule

/* rtl/mi3_recip.sv */
// ------------------------------------------------------------------------
// mi3_recip
// pipelined restoring divider, one quotient bit per stage:
// quo = floor(2^79 / dn) for a normalized 48-bit dn
// ------------------------------------------------------------------------
module mi3_recip (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      en,
    input  logic                      in_valid,
    input  logic [mi3_pkg::DN_W-1:0]  dn,
    input  mi3_pkg::mi3_side_t        in_side,
    output logic                      out_valid,
    output logic [mi3_pkg::QUO_W-1:0] quo,
    output mi3_pkg::mi3_side_t        out_side
);
    import mi3_pkg::*;

    // partial remainder starts at the numerator bits above the quotient
    localparam logic [REM_W-1:0] REM_INIT = REM_W'(1) << (DN_W - 1);

    logic              v_reg   [DIV_STAGES];
    logic [REM_W-1:0]  rem_reg [DIV_STAGES];
    logic [QUO_W-1:0]  q_reg   [DIV_STAGES];
    logic [DN_W-1:0]   d_reg   [DIV_STAGES];
    mi3_side_t         side_reg[DIV_STAGES];

    for (genvar i = 0; i < DIV_STAGES; i++) begin : g_stage
        logic             v_in;
        logic [REM_W-1:0] rem_in;
        logic [QUO_W-1:0] q_in;
        logic [DN_W-1:0]  d_in;
        mi3_side_t        s_in;
        logic             ge;
        logic [REM_W-1:0] diff;

        if (i == 0) begin : g_first
            assign v_in   = in_valid;
            assign rem_in = REM_INIT;
            assign q_in   = '0;
            assign d_in   = dn;
            assign s_in   = in_side;
        end
        else begin : g_rest
            assign v_in   = v_reg[i-1];
            assign rem_in = rem_reg[i-1];
            assign q_in   = q_reg[i-1];
            assign d_in   = d_reg[i-1];
            assign s_in   = side_reg[i-1];
        end

        // compare and subtract for one quotient bit
        assign ge   = rem_in >= {1'b0, d_in};
        assign diff = ge ? (rem_in - {1'b0, d_in}) : rem_in;

        // stage valid
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[i] <= 1'b0;
            end
            else if (en)
            begin
                v_reg[i] <= v_in;
            end
        end

        // stage payload
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[i]  <= {diff[REM_W-2:0], 1'b0};
                q_reg[i]    <= {q_in[QUO_W-2:0], ge};
                d_reg[i]    <= d_in;
                side_reg[i] <= s_in;
            end
        end
    end

    assign out_valid = v_reg[DIV_STAGES-1];
    assign quo       = q_reg[DIV_STAGES-1];
    assign out_side  = side_reg[DIV_STAGES-1];

endmodule

/* test/tb.sv */
// ------------------------------------------------------------------------
// tb
// drives 3x3 Q4.12 matrices into the inverse pipeline, predicts each
// Q16.16 inverse and status, and checks every output transaction in order
// ------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;

    import mi3_pkg::*;

    localparam int LATENCY  = 44;
    localparam int WD_LIMIT = 20000;

    typedef struct {
        logic signed [31:0] elem [9];
        status_t            st;
    } inverse_t;

    logic          clk;
    logic          rst_n;
    logic [143:0]  s_tdata;
    logic          s_tvalid;
    logic          s_tready;
    logic [287:0]  m_tdata;
    logic [1:0]    m_tuser;
    logic          m_tvalid;
    logic          m_tready;
    logic          cfg_we;
    logic [0:0]    cfg_addr;
    logic [30:0]   cfg_wdata;

    // model copy of the registers
    logic [19:0]   thr_reg;
    logic [30:0]   fb_reg;

    inverse_t      inverse_q [$];
    int            err_cnt;
    int            idle_cnt;
    bit            calm;

    mat3_inverse_with_fallback i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tdata   (s_tdata),   // in_r0c0 .. in_r2c2, 16 bits each
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .m_tdata   (m_tdata),   // out_r0c0 .. out_r2c2, 32 bits each
        .m_tuser   (m_tuser),   // status
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    // fallback diagonal matrix
    function automatic inverse_t fallback_of(status_t st);
        inverse_t r;
        for (int k = 0; k < 9; k++)
        begin
            r.elem[k] = (k % 4 == 0) ? {1'b0, fb_reg} : 32'sd0;
        end
        r.st = st;
        return r;
    endfunction

    // adjugate times one normalized reciprocal
    function automatic inverse_t invert_matrix(logic [143:0] m);
        inverse_t          r;
        longint            a [9];
        longint            cf [9];
        longint            det;
        logic [63:0]       dmag;
        logic [63:0]       quo;
        logic [127:0]      prod;
        logic [127:0]      mag;
        int                blen;
        bit                neg;
        for (int k = 0; k < 9; k++)
        begin
            a[k] = longint'($signed(m[16*k +: 16]));
        end
        cf[0] = a[4] * a[8] - a[5] * a[7];
        cf[1] = a[2] * a[7] - a[1] * a[8];
        cf[2] = a[1] * a[5] - a[2] * a[4];
        cf[3] = a[5] * a[6] - a[3] * a[8];
        cf[4] = a[0] * a[8] - a[2] * a[6];
        cf[5] = a[2] * a[3] - a[0] * a[5];
        cf[6] = a[3] * a[7] - a[4] * a[6];
        cf[7] = a[1] * a[6] - a[0] * a[7];
        cf[8] = a[0] * a[4] - a[1] * a[3];
        det  = a[0] * cf[0] + a[1] * cf[3] + a[2] * cf[6];
        dmag = (det < 0) ? -det : det;
        if (dmag < 64'(thr_reg))
        begin
            return fallback_of(ST_SINGULAR);
        end
        if (dmag == 0)
        begin
            return fallback_of(ST_OVERFLOW);
        end
        blen = 0;
        while ((dmag >> blen) != 0)
        begin
            blen++;
        end
        quo = 64'((128'd1 << (blen + 31)) / dmag);
        for (int k = 0; k < 9; k++)
        begin
            prod = 128'((cf[k] < 0) ? -cf[k] : cf[k]) * 128'(quo);
            mag  = (prod + (128'd1 << (blen + 2))) >> (blen + 3);
            neg  = (mag != 0) && ((cf[k] < 0) != (det < 0));
            if (neg ? (mag > 128'h8000_0000) : (mag > 128'h7FFF_FFFF))
            begin
                return fallback_of(ST_OVERFLOW);
            end
            r.elem[k] = neg ? -mag[31:0] : mag[31:0];
        end
        r.st = ST_INVERTED;
        return r;
    endfunction

    // send one matrix with an optional random gap first
    task automatic send_matrix(logic [143:0] m);
        int gap;
        if (!calm && $urandom_range(0, 5) == 0)
        begin
            gap = $urandom_range(1, 17);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tdata  <= m;
        s_tvalid <= 1'b1;
        @(posedge clk);
        while (!s_tready)
        begin
            @(posedge clk);
        end
        inverse_q.push_back(invert_matrix(m));
    endtask

    task automatic drop_valid();
        s_tvalid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (inverse_q.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (LATENCY + 4) @(posedge clk);
    endtask

    // one register write, after which the write port goes quiet
    task automatic write_reg(cfg_index_t idx, logic [30:0] val);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        cfg_we    <= 1'b0;
        @(posedge clk);
        if (idx == CFG_THRESHOLD)
        begin
            thr_reg = val[19:0];
        end
        else
        begin
            fb_reg = val;
        end
    endtask

    function automatic logic [143:0] pack9(int v [9]);
        logic [143:0] m;
        for (int k = 0; k < 9; k++)
        begin
            m[16*k +: 16] = 16'(v[k]);
        end
        return m;
    endfunction

    function automatic logic [143:0] rand_matrix();
        logic [143:0] m;
        int           mode;
        mode = $urandom_range(0, 9);
        for (int k = 0; k < 9; k++)
        begin
            case (mode)
                0:       m[16*k +: 16] = 16'($urandom);
                1:       m[16*k +: 16] = 16'($urandom_range(0, 15)) - 16'd8;
                2:       m[16*k +: 16] = (k % 4 == 0) ? 16'($urandom) : 16'd0;
                default: m[16*k +: 16] = 16'($signed(16'($urandom_range(0, 16383))) - 8192);
            endcase
        end
        // rank-deficient: copy row 0 into row 2
        if (mode == 3)
        begin
            m[143:96] = m[47:0];
        end
        return m;
    endfunction

    // directed corner matrices at reset settings, then with a zero threshold
    task automatic test_directed();
        int id [9]   = '{4096, 0, 0, 0, 4096, 0, 0, 0, 4096};
        int neg [9]  = '{-4096, 0, 0, 0, 4096, 0, 0, 0, 4096};
        int maxm [9] = '{32767, 0, 0, 0, 32767, 0, 0, 0, 32767};
        int minm [9] = '{-32768, 0, 0, 0, -32768, 0, 0, 0, -32768};
        int tiny [9] = '{1, 0, 0, 0, 1, 0, 0, 0, 1};
        int big [9]  = '{1, 0, 0, 0, 1, 0, 0, 0, 8};
        int gen [9]  = '{2, 1, 0, 1, 3, 1, 0, 1, 4};
        int all1 [9] = '{-1, -1, -1, -1, -1, -1, -1, -1, -1};
        int mix [9]  = '{32767, -32768, 1234, -32768, 32767, -1, 5, 7, -32768};
        send_matrix(pack9(id));
        send_matrix(pack9(neg));
        send_matrix(pack9(maxm));
        send_matrix(pack9(minm));
        send_matrix(pack9(tiny));
        send_matrix(pack9(big));
        send_matrix(pack9(gen));
        send_matrix(pack9(all1));
        send_matrix(pack9(mix));
        send_matrix('0);
        send_matrix('1);
        drain();
        // zero determinant with a zero threshold
        write_reg(CFG_THRESHOLD, 31'd0);
        send_matrix('0);
        send_matrix(pack9(tiny));
        send_matrix(pack9(gen));
        drain();
    endtask

    // register extremes, each with a short burst of traffic
    task automatic test_config_sweep();
        logic [30:0] thr_set [4] = '{31'd0, 31'd1, 31'hFFFFF, 31'd300};
        logic [30:0] fb_set [4]  = '{31'd0, 31'h7FFFFFFF, 31'd65536, 31'd65543};
        for (int p = 0; p < 4; p++)
        begin
            write_reg(CFG_THRESHOLD, thr_set[p]);
            write_reg(CFG_FALLBACK, fb_set[p]);
            repeat (60) send_matrix(rand_matrix());
            drain();
        end
        write_reg(CFG_THRESHOLD, 31'd7);
    endtask

    // long random run, idling stops near the end
    task automatic test_random();
        for (int n = 0; n < 660; n++)
        begin
            if (n == 560)
            begin
                calm = 1'b1;
            end
            send_matrix(rand_matrix());
        end
        drop_valid();
    endtask

    // receiver stalls in random bursts
    initial
    begin
        int b;
        m_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (!calm && $urandom_range(0, 4) == 0)
            begin
                b = $urandom_range(1, 17);
                m_tready <= 1'b0;
                repeat (b) @(posedge clk);
            end
            else
            begin
                m_tready <= 1'b1;
                repeat ($urandom_range(1, 20)) @(posedge clk);
            end
        end
    end

    // compare each output transaction with the oldest prediction
    always @(posedge clk)
    begin
        inverse_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (inverse_q.size() == 0)
            begin
                $error("unexpected output transaction");
                err_cnt++;
            end
            else
            begin
                want = inverse_q.pop_front();
                for (int k = 0; k < 9; k++)
                begin
                    if (m_tdata[32*k +: 32] !== want.elem[k])
                    begin
                        $error("out_r%0dc%0d: expected %0d, got %0d", k / 3, k % 3,
                               want.elem[k], $signed(m_tdata[32*k +: 32]));
                        err_cnt++;
                    end
                end
                if (m_tuser !== want.st)
                begin
                    $error("status: expected %0d, got %0d", want.st, m_tuser);
                    err_cnt++;
                end
            end
        end
    end

    // watchdog on cycles with no transaction
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we)
        begin
            idle_cnt <= 0;
        end
        else
        begin
            idle_cnt <= idle_cnt + 1;
        end
        if (idle_cnt > WD_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial
    begin
        rst_n     = 1'b0;
        s_tdata   = '0;
        s_tvalid  = 1'b0;
        cfg_we    = 1'b0;
        cfg_addr  = CFG_THRESHOLD;
        cfg_wdata = '0;
        thr_reg   = THR_RESET;
        fb_reg    = FB_RESET;
        err_cnt   = 0;
        idle_cnt  = 0;
        calm      = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_config_sweep();
        test_random();
        drain();
        if (err_cnt == 0)
        begin
            $display("DONE: 0 errors");
        end
        else
        begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
